FILE: sv/ucd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the cycle detector.
`default_nettype none

package ucd_pkg;

    // Fixed field widths
    localparam int KIND_W = 2;
    localparam int VTX_W  = 6;
    localparam int WGT_W  = 32;
    localparam int CNT_W  = 7;

    // Register reset and default graph size
    localparam logic [CNT_W-1:0] VCOUNT_RESET     = 7'd64;
    localparam int               MAX_VERTICES_DEF = 64;

    // Item kinds; code 3 is ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_graph;
        logic rd_row_a;
        logic wr_row_a;
        logic rd_row_b;
        logic wr_row_b;
        logic q_init;
        logic root_next;
        logic root_open;
        logic row_latch;
        logic pop;
        logic advance;
        logic push;
        logic mark_only;
        logic set_found;
        logic frame_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic edge_ok;
        logic root_end;
        logic root_visited;
        logic next_end;
        logic bit_set;
        logic i_visited;
        logic i_is_parent;
        logic depth_one;
        logic depth_full;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/ucd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/ucd_ctrl.sv
// Controller state machine: sequences edge updates and the depth-first search.
`default_nettype none

module ucd_ctrl import ucd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic                   o_busy,
    output logic                   o_result_valid
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_E_RDA  = 11'b000_0000_0010,
        S_E_WRA  = 11'b000_0000_0100,
        S_E_RDB  = 11'b000_0000_1000,
        S_E_WRB  = 11'b000_0001_0000,
        S_Q_INIT = 11'b000_0010_0000,
        S_Q_ROOT = 11'b000_0100_0000,
        S_Q_LOAD = 11'b000_1000_0000,
        S_Q_SCAN = 11'b001_0000_0000,
        S_Q_POPF = 11'b010_0000_0000,
        S_Q_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_kind)
                        KIND_CLEAR: o_cmd.clear_graph = 1'b1;
                        KIND_EDGE:  n_state = S_E_RDA;
                        KIND_QUERY: n_state = S_Q_INIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_E_RDA: begin
                if (i_stat.edge_ok) begin
                    o_cmd.rd_row_a = 1'b1;
                    n_state        = S_E_WRA;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_E_WRA: begin
                o_cmd.wr_row_a = 1'b1;
                n_state        = S_E_RDB;
            end
            S_E_RDB: begin
                o_cmd.rd_row_b = 1'b1;
                n_state        = S_E_WRB;
            end
            S_E_WRB: begin
                o_cmd.wr_row_b = 1'b1;
                n_state        = S_IDLE;
            end
            S_Q_INIT: begin
                o_cmd.q_init = 1'b1;
                n_state      = S_Q_ROOT;
            end
            S_Q_ROOT: begin
                if (i_stat.root_end) begin
                    n_state = S_Q_DONE;
                end else if (i_stat.root_visited) begin
                    o_cmd.root_next = 1'b1;
                end else begin
                    o_cmd.root_open = 1'b1;
                    n_state         = S_Q_LOAD;
                end
            end
            S_Q_LOAD: begin
                o_cmd.row_latch = 1'b1;
                n_state         = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                if (i_stat.next_end) begin
                    // frame exhausted: pop it
                    o_cmd.pop = 1'b1;
                    if (i_stat.depth_one) begin
                        o_cmd.root_next = 1'b1;
                        n_state         = S_Q_ROOT;
                    end else begin
                        n_state = S_Q_POPF;
                    end
                end else if (i_stat.bit_set && !i_stat.i_visited) begin
                    // new vertex: descend, or just mark it when the stack is full
                    if (i_stat.depth_full) begin
                        o_cmd.mark_only = 1'b1;
                        o_cmd.advance   = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_Q_LOAD;
                    end
                end else if (i_stat.bit_set && !i_stat.i_is_parent) begin
                    // back edge to a visited non-parent vertex
                    o_cmd.set_found = 1'b1;
                    n_state         = S_Q_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_Q_POPF: begin
                o_cmd.frame_load = 1'b1;
                n_state          = S_Q_LOAD;
            end
            S_Q_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_Q_DONE);

endmodule

`default_nettype wire

FILE: sv/ucd_datapath.sv
// Datapath: adjacency memory, visited marks, search stack and top-of-stack frame.
`default_nettype none

module ucd_datapath import ucd_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic [VTX_W-1:0]        i_vertex_a,
    input  wire logic [VTX_W-1:0]        i_vertex_b,
    input  wire logic signed [WGT_W-1:0] i_edge_weight,
    input  wire t_cmd                    i_cmd,
    output t_stat                        o_stat,
    output logic                         o_has_cycle
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int KW = (CW > CNT_W) ? CW : CNT_W;
    localparam int FW = 2 * VW + 1 + CW;

    // Configuration and captured item
    logic [CNT_W-1:0]        r_vcount;
    logic [VTX_W-1:0]        r_a;
    logic [VTX_W-1:0]        r_b;
    logic                    r_bit;

    // Search state
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_row;
    logic                    r_rd_vld;
    logic [CW-1:0]           r_root;
    logic [CW-1:0]           r_next;
    logic [CW-1:0]           r_depth;
    logic [VW-1:0]           r_vertex;
    logic [VW-1:0]           r_parent;
    logic                    r_hp;
    logic                    r_found;

    logic [KW-1:0]           w_n_k;
    logic [CW-1:0]           w_n;
    logic [KW-1:0]           w_a_k;
    logic [KW-1:0]           w_b_k;
    logic [VW-1:0]           w_a;
    logic [VW-1:0]           w_b;
    logic [VW-1:0]           w_i;
    logic [VW-1:0]           w_root_v;
    logic [CW-1:0]           w_dm1;
    logic [CW-1:0]           w_dm2;
    logic [MAX_VERTICES-1:0] w_base;

    logic                    adj_we;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;

    logic                    stk_we;
    logic [FW-1:0]           stk_wdata;
    logic [FW-1:0]           stk_rdata;
    logic [VW-1:0]           f_vertex;
    logic [VW-1:0]           f_parent;
    logic                    f_hp;
    logic [CW-1:0]           f_next;

    // Active vertex count = min(vertex_count, MAX_VERTICES)
    assign w_n_k = (KW'(r_vcount) < KW'(MAX_VERTICES)) ? KW'(r_vcount) : KW'(MAX_VERTICES);
    assign w_n   = w_n_k[CW-1:0];

    assign w_a_k    = KW'(r_a);
    assign w_b_k    = KW'(r_b);
    assign w_a      = w_a_k[VW-1:0];
    assign w_b      = w_b_k[VW-1:0];
    assign w_i      = r_next[VW-1:0];
    assign w_root_v = r_root[VW-1:0];
    assign w_dm1    = r_depth - CW'(1);
    assign w_dm2    = r_depth - CW'(2);

    // Rows never written since the last clear read as zero
    assign w_base = r_rd_vld ? adj_rdata : '0;

    // Status to the controller
    always_comb begin
        o_stat.edge_ok      = (w_a_k < w_n_k) && (w_b_k < w_n_k);
        o_stat.root_end     = (r_root >= w_n);
        o_stat.root_visited = r_visited[w_root_v];
        o_stat.next_end     = (r_next >= w_n);
        o_stat.bit_set      = r_row[w_i];
        o_stat.i_visited    = r_visited[w_i];
        o_stat.i_is_parent  = r_hp && (r_parent == w_i);
        o_stat.depth_one    = (r_depth == CW'(1));
        o_stat.depth_full   = (r_depth == CW'(MAX_VERTICES));
    end

    // Adjacency memory address and write data
    always_comb begin
        adj_raddr = w_a;
        if (i_cmd.rd_row_a) begin
            adj_raddr = w_a;
        end
        if (i_cmd.rd_row_b) begin
            adj_raddr = w_b;
        end
        if (i_cmd.root_open) begin
            adj_raddr = w_root_v;
        end
        if (i_cmd.push) begin
            adj_raddr = w_i;
        end
        if (i_cmd.frame_load) begin
            adj_raddr = f_vertex;
        end

        adj_we    = 1'b0;
        adj_waddr = w_a;
        adj_wdata = w_base;
        if (i_cmd.wr_row_a) begin
            adj_we         = 1'b1;
            adj_wdata[w_b] = r_bit;
        end
        if (i_cmd.wr_row_b) begin
            adj_we         = 1'b1;
            adj_waddr      = w_b;
            adj_wdata[w_a] = r_bit;
        end
    end

    ucd_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // Stack frames below the top: {vertex, parent, has_parent, next}
    assign stk_we    = i_cmd.push;
    assign stk_wdata = {r_vertex, r_parent, r_hp, r_next + CW'(1)};
    assign f_vertex  = stk_rdata[FW-1 -: VW];
    assign f_parent  = stk_rdata[FW-1-VW -: VW];
    assign f_hp      = stk_rdata[CW];
    assign f_next    = stk_rdata[CW-1:0];

    ucd_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (w_dm1[VW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (w_dm2[VW-1:0]),
        .o_rdata (stk_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= VCOUNT_RESET;
            r_row_vld <= '0;
            r_root    <= '0;
            r_next    <= '0;
            r_depth   <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.clear_graph) begin
                r_row_vld <= '0;
            end else if (adj_we) begin
                r_row_vld[adj_waddr] <= 1'b1;
            end
            if (i_cmd.q_init) begin
                r_root  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.root_next) begin
                r_root <= r_root + CW'(1);
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.root_open) begin
                r_next  <= '0;
                r_depth <= CW'(1);
            end
            if (i_cmd.pop) begin
                r_depth <= w_dm1;
            end
            if (i_cmd.advance) begin
                r_next <= r_next + CW'(1);
            end
            if (i_cmd.push) begin
                r_next  <= '0;
                r_depth <= r_depth + CW'(1);
            end
            if (i_cmd.frame_load) begin
                r_next <= f_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[adj_raddr];
        if (i_cmd.capture) begin
            r_a   <= i_vertex_a;
            r_b   <= i_vertex_b;
            r_bit <= (i_edge_weight != '0);
        end
        if (i_cmd.q_init) begin
            r_visited <= '0;
        end
        if (i_cmd.row_latch) begin
            r_row <= w_base;
        end
        if (i_cmd.root_open) begin
            r_visited[w_root_v] <= 1'b1;
            r_vertex            <= w_root_v;
            r_parent            <= '0;
            r_hp                <= 1'b0;
        end
        if (i_cmd.mark_only) begin
            r_visited[w_i] <= 1'b1;
        end
        if (i_cmd.push) begin
            r_visited[w_i] <= 1'b1;
            r_vertex       <= w_i;
            r_parent       <= r_vertex;
            r_hp           <= 1'b1;
        end
        if (i_cmd.frame_load) begin
            r_vertex <= f_vertex;
            r_parent <= f_parent;
            r_hp     <= f_hp;
        end
    end

    assign o_has_cycle = r_found;

endmodule

`default_nettype wire

FILE: sv/undirected_cycle_detect_unit.sv
// Top level of the undirected graph cycle detector.
`default_nettype none

// Command-style block: a word is taken when start is high and busy is low.
// A clear word is applied as it is taken and busy stays low. An edge word keeps
// busy high for a read-modify-write of two rows, each read waiting on the
// registered adjacency memory output; an edge naming a vertex at or beyond
// the active count drops busy after the range check alone. A query keeps busy
// high for the whole search, which tests one column of the current row per
// cycle, and each descent or return waits for a registered memory read. The
// answer appears on o_has_cycle with o_result_valid high for exactly one cycle
// and cannot be stalled. Clear works through per-row valid flags, so there is
// no clearing pass after reset. Write i_cfg_data only while busy is low.
module undirected_cycle_detect_unit import ucd_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [KIND_W-1:0]       i_kind,
    input  wire logic [VTX_W-1:0]        i_vertex_a,
    input  wire logic [VTX_W-1:0]        i_vertex_b,
    input  wire logic signed [WGT_W-1:0] i_edge_weight,
    output logic                         o_result_valid,
    output logic                         o_has_cycle
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ucd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_kind         (i_kind),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    ucd_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_vertex_a    (i_vertex_a),
        .i_vertex_b    (i_vertex_b),
        .i_edge_weight (i_edge_weight),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_has_cycle   (o_has_cycle)
    );

endmodule

`default_nettype wire

FILE: bench/undirected_cycle_detect_unit_tb.sv
// Self-checking bench for the undirected cycle detector: random graphs, queries and size changes.
`timescale 1ns / 1ps

module undirected_cycle_detect_unit_tb import ucd_pkg::*; ();

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 7;
    localparam int RAND_WORDS = 650;
    localparam int SETTLE     = 8;     // idle cycles before a size write
    localparam int TAIL       = 16;    // idle cycles before the verdict
    // Watchdog bound: allows every word to be a query over 64 vertices, 4x over.
    localparam longint LIMIT  = 12_000_000;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // decoded as nothing

    typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} t_act;

    typedef struct {
        t_act                    act;
        logic [KIND_W-1:0]       kind;
        logic [VTX_W-1:0]        va;
        logic [VTX_W-1:0]        vb;
        logic signed [WGT_W-1:0] wt;
        logic [CNT_W-1:0]        size;
    } t_pend;

    // DUT ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CNT_W-1:0]        i_cfg_data = '0;
    logic                    start = 1'b0;
    logic [KIND_W-1:0]       i_kind = '0;
    logic [VTX_W-1:0]        i_vertex_a = '0;
    logic [VTX_W-1:0]        i_vertex_b = '0;
    logic signed [WGT_W-1:0] i_edge_weight = '0;
    logic                    busy;
    logic                    o_result_valid;
    logic                    o_has_cycle;

    // Stimulus and scoreboard state
    t_pend       pending_words[$];
    logic        cycle_expect[$];
    logic [63:0] adj_rows [64];
    logic [CNT_W-1:0] graph_size;
    int          row_i;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        took = 1'b0;
    logic        exp_bit;

    // Driver state
    t_pend       head;
    logic        nxt_start;
    logic        nxt_we;
    int          burst_left = 1;
    int          gap_left = 0;

    // Generator state
    int          gen_n = 64;
    int          words_made = 0;
    int          perm [64];

    undirected_cycle_detect_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_edge_weight  (i_edge_weight),
        .o_result_valid (o_result_valid),
        .o_has_cycle    (o_has_cycle)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------- predictor ----------------

    function automatic int active_n();
        return (graph_size > 7'd64) ? 64 : int'(graph_size);
    endfunction

    function automatic void apply_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                       logic present);
        int n;
        n = active_n();
        if (a < n && b < n) begin
            adj_rows[a][b] = present;
            adj_rows[b][a] = present;
        end
    endfunction

    // Union-find over visible edges: a self-loop or an edge inside one set closes a loop
    function automatic logic graph_has_cycle();
        int n;
        int ri;
        int rj;
        int rep [64];
        n = active_n();
        for (int i = 0; i < 64; i++) rep[i] = i;
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                if (adj_rows[i][j]) begin
                    if (i == j) return 1'b1;
                    ri = i;
                    while (rep[ri] != ri) ri = rep[ri];
                    rj = j;
                    while (rep[rj] != rj) rj = rep[rj];
                    if (ri == rj) return 1'b1;
                    rep[ri] = rj;
                end
            end
        end
        return 1'b0;
    endfunction

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (row_i = 0; row_i < 64; row_i++) adj_rows[row_i] = '0;
            graph_size = VCOUNT_RESET;
            took <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            // result word check
            if (o_result_valid) begin
                if (cycle_expect.size() == 0) begin
                    $error("has_cycle: no query outstanding, actual %0d", o_has_cycle);
                    mismatches++;
                end else begin
                    exp_bit = cycle_expect.pop_front();
                    if (o_has_cycle !== exp_bit) begin
                        $error("has_cycle: expected %0d, actual %0d", exp_bit, o_has_cycle);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) graph_size = i_cfg_data;
            // accepted input word
            if (start && !busy) begin
                case (i_kind)
                    KIND_CLEAR: for (row_i = 0; row_i < 64; row_i++) adj_rows[row_i] = '0;
                    KIND_EDGE:  apply_edge(i_vertex_a, i_vertex_b, i_edge_weight != 0);
                    KIND_QUERY: cycle_expect.push_back(graph_has_cycle());
                    default: ;
                endcase
            end
            took <= start && !busy;
            quiet_cycles <= (busy || start || o_result_valid || cycle_expect.size() != 0)
                            ? 0 : quiet_cycles + 1;
        end
    end

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            nxt_start = start;
            nxt_we    = 1'b0;
            // hold a word until it is taken
            if (!(start && !took)) begin
                nxt_start = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    head = pending_words[0];
                    if (head.act == ACT_WORD) begin
                        void'(pending_words.pop_front());
                        nxt_start = 1'b1;
                        i_kind        <= head.kind;
                        i_vertex_a    <= head.va;
                        i_vertex_b    <= head.vb;
                        i_edge_weight <= head.wt;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                                     : $urandom_range(1, 10);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 8);
                        end
                    end else if (quiet_cycles >= SETTLE) begin
                        // size writes and pauses wait for an idle block
                        void'(pending_words.pop_front());
                        if (head.act == ACT_CFG) begin
                            nxt_we = 1'b1;
                            i_cfg_data <= head.size;
                        end
                    end
                end
            end
            start    <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_word(logic [KIND_W-1:0] kind, int a, int b,
                             logic signed [WGT_W-1:0] w);
        t_pend p;
        p.act  = ACT_WORD;
        p.kind = kind;
        p.va   = a[VTX_W-1:0];
        p.vb   = b[VTX_W-1:0];
        p.wt   = w;
        p.size = '0;
        pending_words.push_back(p);
        if (kind == KIND_CLEAR || kind == KIND_QUERY ||
            (kind == KIND_EDGE && a < gen_n && b < gen_n))
            words_made++;
    endtask

    task automatic push_cfg(int sz);
        t_pend p;
        p.act  = ACT_CFG;
        p.kind = KIND_CLEAR;
        p.va   = '0;
        p.vb   = '0;
        p.wt   = '0;
        p.size = sz[CNT_W-1:0];
        pending_words.push_back(p);
        gen_n = (sz > 64) ? 64 : sz;
    endtask

    task automatic push_drain();
        t_pend p;
        p.act  = ACT_DRAIN;
        p.kind = KIND_CLEAR;
        p.va   = '0;
        p.vb   = '0;
        p.wt   = '0;
        p.size = '0;
        pending_words.push_back(p);
    endtask

    function automatic logic signed [WGT_W-1:0] nz_weight();
        logic [WGT_W-1:0] w;
        w = $urandom;
        return (w == 0) ? 32'sd1 : w;
    endfunction

    function automatic int rv();
        return $urandom_range(0, 63);
    endfunction

    // Ignored kind, out-of-range edge, random edge or a repeat of the first tree edge
    task automatic push_noise();
        int hi;
        case ($urandom_range(0, 3))
            0: push_word(KIND_NONE, rv(), rv(), $urandom);
            1: begin
                if (gen_n < 64) begin
                    hi = $urandom_range(gen_n, 63);
                    if ($urandom_range(0, 1)) push_word(KIND_EDGE, hi, rv(), nz_weight());
                    else                      push_word(KIND_EDGE, rv(), hi, nz_weight());
                end
            end
            2: push_word(KIND_EDGE, $urandom_range(0, gen_n - 1), $urandom_range(0, gen_n - 1),
                         $urandom);
            default: push_word(KIND_EDGE, perm[1], perm[0], nz_weight());
        endcase
    endtask

    task automatic shuffle_vertices();
        int j;
        int tmp;
        for (int i = 0; i < gen_n; i++) perm[i] = i;
        for (int i = gen_n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
    endtask

    // One round: a random tree, query, maybe close a loop, query, maybe open it again
    task automatic tree_round();
        int k;
        int a;
        int b;
        if (gen_n < 2) begin
            repeat ($urandom_range(1, 3)) push_word(KIND_EDGE, rv(), rv(), nz_weight());
            if (gen_n == 1)
                push_word(KIND_EDGE, 0, 0, $urandom_range(0, 1) ? nz_weight() : 32'sd0);
            push_word(KIND_QUERY, rv(), rv(), $urandom);
        end else begin
            if ($urandom_range(0, 1)) push_word(KIND_CLEAR, rv(), rv(), $urandom);
            shuffle_vertices();
            k = $urandom_range(1, (gen_n - 1 < 12) ? gen_n - 1 : 12);
            for (int t = 1; t <= k; t++) begin
                push_word(KIND_EDGE, perm[t], perm[$urandom_range(0, t - 1)], nz_weight());
                if ($urandom_range(0, 9) == 0) push_noise();
            end
            push_word(KIND_QUERY, rv(), rv(), $urandom);
            if ($urandom_range(0, 2) != 0) begin
                a = perm[$urandom_range(0, k)];
                b = ($urandom_range(0, 3) == 0) ? a : perm[$urandom_range(0, k)];
                push_word(KIND_EDGE, a, b, nz_weight());
                push_word(KIND_QUERY, rv(), rv(), $urandom);
                if ($urandom_range(0, 1)) begin
                    push_word(KIND_EDGE, b, a, 32'sd0);
                    push_word(KIND_QUERY, rv(), rv(), $urandom);
                end
            end
        end
    endtask

    initial begin
        int sz;

        // directed: extremes, triangle, self-loop, repeated edge, size changes
        push_cfg(64);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_EDGE, 0, 63, 32'sh8000_0000);
        push_word(KIND_EDGE, 63, 62, 32'sh7FFF_FFFF);
        push_word(KIND_EDGE, 62, 0, -32'sd1);
        push_word(KIND_QUERY, 63, 63, -32'sd1);
        push_word(KIND_EDGE, 62, 0, 32'sd0);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_EDGE, 5, 5, 32'sd1);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_EDGE, 5, 5, 32'sd0);
        push_word(KIND_EDGE, 1, 2, 32'sd1);
        push_word(KIND_EDGE, 2, 1, 32'sd7);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_NONE, 21, 42, 32'sh5555_AAAA);
        push_word(KIND_EDGE, 40, 41, 32'sd1);
        push_word(KIND_EDGE, 41, 42, 32'sd1);
        push_word(KIND_EDGE, 42, 40, 32'sd1);
        // lowered count hides the high loop, raising it brings it back
        push_cfg(10);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_EDGE, 3, 20, 32'sd1);
        push_word(KIND_QUERY, 0, 0, 0);
        push_drain();
        push_cfg(64);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_CLEAR, 63, 63, -32'sd1);
        push_word(KIND_QUERY, 0, 0, 0);
        push_cfg(0);
        push_word(KIND_EDGE, 0, 0, 32'sd1);
        push_word(KIND_QUERY, 0, 0, 0);
        push_cfg(127);
        push_word(KIND_QUERY, 0, 0, 0);
        push_cfg(1);
        push_word(KIND_EDGE, 0, 0, 32'sd1);
        push_word(KIND_QUERY, 0, 0, 0);

        // random phases, mostly small graphs
        words_made = 0;
        while (words_made < RAND_WORDS) begin
            case ($urandom_range(0, 19))
                0:       sz = 0;
                1:       sz = 1;
                2:       sz = 127;
                3:       sz = 64;
                4, 5:    sz = $urandom_range(33, 63);
                default: sz = $urandom_range(2, 16);
            endcase
            push_cfg(sz);
            push_word(KIND_CLEAR, rv(), rv(), $urandom);
            repeat ($urandom_range(2, 5)) begin
                tree_round();
                if ($urandom_range(0, 7) == 0) push_drain();
            end
        end

        while (pending_words.size() != 0) @(posedge i_clk);
        while (quiet_cycles < TAIL) @(posedge i_clk);
        if (mismatches == 0)
            $display("undirected_cycle_detect_unit: match");
        else
            $display("undirected_cycle_detect_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        for (longint c = 0; c < LIMIT; c++) @(posedge i_clk);
        $display("undirected_cycle_detect_unit: mismatch");
        $finish;
    end

endmodule

FILE: undirected_cycle_detect_unit.f
sv/ucd_pkg.sv
sv/ucd_ram.sv
sv/ucd_ctrl.sv
sv/ucd_datapath.sv
sv/undirected_cycle_detect_unit.sv
bench/undirected_cycle_detect_unit_tb.sv
